// ----- hdl/wac_pkg.sv -----
`default_nettype none
package wac_pkg;

  // field widths
  localparam int AddrW      = 48;
  localparam int SectW      = 3;
  localparam int KeyW       = AddrW + SectW;
  localparam int CntW       = 6;
  localparam int CfgW       = 4;

  // geometry
  localparam int SectorLog2 = 5;   // 32-byte sectors
  localparam int MaxUnique  = 32;
  localparam int IdxW       = $clog2(MaxUnique);

  // line size limits and reset value
  localparam logic [CfgW-1:0] LineLog2Min   = CfgW'(5);
  localparam logic [CfgW-1:0] LineLog2Max   = CfgW'(8);
  localparam logic [CfgW-1:0] LineLog2Reset = CfgW'(7);

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the accepted request
    logic rd;       // read the table entry at the scan index
    logic cmp;      // compare the read entry, advance the scan index on a miss
    logic fin;      // update the table and load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;   // table empty
    logic hit;        // read entry matches the key
    logic scan_last;  // scan index is the last stored entry
    logic out_busy;   // output register holds a result that is not taken
  } status_t;

endpackage
`default_nettype wire

// ----- hdl/wac_ram.sv -----
`default_nettype none
module wac_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/wac_ctrl.sv -----
`default_nettype none
module wac_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire wac_pkg::status_t sts_i,
  output wac_pkg::cmd_t         cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.cnt_zero ? S_FIN : S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.hit || sts_i.scan_last) begin
          state_d = S_FIN;
        end else begin
          state_d = S_READ;
        end
      end
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/wac_dp.sv -----
`default_nettype none
module wac_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [wac_pkg::CfgW-1:0]   cfg_line_size_log2_i,
  input  wire logic [wac_pkg::AddrW-1:0]  thread_address_i,
  input  wire logic                       last_address_i,
  input  wire wac_pkg::cmd_t              cmd_i,
  output wac_pkg::status_t                sts_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [wac_pkg::AddrW-1:0]       line_address_o,
  output logic [wac_pkg::SectW-1:0]       sector_index_o,
  output logic                            is_new_request_o,
  output logic [wac_pkg::CntW-1:0]        request_count_o,
  output logic                            table_full_o,
  output logic                            access_done_o
);

  logic [wac_pkg::CfgW-1:0]  line_log2_q;
  logic [wac_pkg::CfgW-1:0]  eff_log2;
  logic [wac_pkg::AddrW-1:0] line_d;
  logic [wac_pkg::SectW-1:0] sect_d;

  logic [wac_pkg::AddrW-1:0] line_q;
  logic [wac_pkg::SectW-1:0] sect_q;
  logic                      last_q;
  logic                      found_q;
  logic [wac_pkg::IdxW-1:0]  idx_q;
  logic [wac_pkg::CntW-1:0]  cnt_q;
  logic                      out_valid_q;

  logic [wac_pkg::KeyW-1:0]  key;
  logic [wac_pkg::KeyW-1:0]  rdata;
  logic                      room;
  logic                      store;
  logic [wac_pkg::CntW-1:0]  cnt_next;

  // line size register, clamped to the supported range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_log2_q <= wac_pkg::LineLog2Reset;
    end else if (cfg_valid_i) begin
      line_log2_q <= cfg_line_size_log2_i;
    end
  end

  always_comb begin
    if (line_log2_q < wac_pkg::LineLog2Min) begin
      eff_log2 = wac_pkg::LineLog2Min;
    end else if (line_log2_q > wac_pkg::LineLog2Max) begin
      eff_log2 = wac_pkg::LineLog2Max;
    end else begin
      eff_log2 = line_log2_q;
    end
  end

  // split the address into line and sector
  always_comb begin
    for (int i = 0; i < wac_pkg::AddrW; i++) begin
      line_d[i] = thread_address_i[i] & (i >= int'(eff_log2));
    end
    for (int b = 0; b < wac_pkg::SectW; b++) begin
      sect_d[b] = thread_address_i[wac_pkg::SectorLog2 + b]
                  & ((wac_pkg::SectorLog2 + b) < int'(eff_log2));
    end
  end

  assign key      = {sect_q, line_q};
  assign room     = cnt_q < wac_pkg::CntW'(wac_pkg::MaxUnique);
  assign store    = cmd_i.fin && !found_q && room;
  assign cnt_next = (!found_q && room) ? cnt_q + 1'b1 : cnt_q;

  wac_ram #(
    .Width (wac_pkg::KeyW),
    .Depth (wac_pkg::MaxUnique)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (cnt_q[wac_pkg::IdxW-1:0]),
    .wdata_i (key),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // request capture and scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      line_q <= line_d;
      sect_q <= sect_d;
      last_q <= last_address_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.cmp) begin
        if (rdata == key) begin
          found_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (cmd_i.fin) begin
        cnt_q <= last_q ? '0 : cnt_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      line_address_o   <= line_q;
      sector_index_o   <= sect_q;
      is_new_request_o <= !found_q;
      request_count_o  <= cnt_next;
      table_full_o     <= !found_q && !room;
      access_done_o    <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.cnt_zero  = cnt_q == '0;
  assign sts_o.hit       = rdata == key;
  assign sts_o.scan_last = ({1'b0, idx_q} + 1'b1) == cnt_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule
`default_nettype wire

// ----- hdl/warp_address_coalescer.sv -----
// warp address coalescer, sector granularity
//
// request channel: in_valid_i / in_ready_o carry one thread byte address and
// a flag on the last address of a warp access. each request gives exactly one
// result on the out_valid_o / out_ready_i channel: the line-aligned address,
// the sector index, whether the (line, sector) pair is new in this access, the
// running count of distinct pairs, a full flag and the access-done flag.
// config channel: cfg_valid_i writes the line size log2 (always ready); write
// it only while no request is in flight.
// the pair table is a memory with a single read port; each stored pair that is
// scanned is first read, then compared, and the scan stops at a hit or at the
// last stored pair. a request with an empty table goes straight to finish.
// throughput: one request at a time, the next is taken as soon as the
// controller is back in idle, also while the previous result still waits.
// receiver stall: the result sits in the output register; the controller holds
// the next result until the register is free, and takes no requests meanwhile.
// reset: table empty, line size log2 = 7, no result pending; the memory itself
// needs no clearing since only entries below the fill count are ever read.
`default_nettype none
module warp_address_coalescer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // config write
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [wac_pkg::CfgW-1:0]  cfg_line_size_log2_i,
  // request
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [wac_pkg::AddrW-1:0] thread_address_i,
  input  wire logic                      last_address_i,
  // result
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [wac_pkg::AddrW-1:0]      line_address_o,
  output logic [wac_pkg::SectW-1:0]      sector_index_o,
  output logic                           is_new_request_o,
  output logic [wac_pkg::CntW-1:0]       request_count_o,
  output logic                           table_full_o,
  output logic                           access_done_o
);

  wac_pkg::cmd_t    cmd;
  wac_pkg::status_t sts;

  // the config register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: idle -> (read -> compare)* -> finish
  wac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // address split, pair table, fill count and output register
  wac_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_line_size_log2_i (cfg_line_size_log2_i),
    .thread_address_i     (thread_address_i),
    .last_address_i       (last_address_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .line_address_o       (line_address_o),
    .sector_index_o       (sector_index_o),
    .is_new_request_o     (is_new_request_o),
    .request_count_o      (request_count_o),
    .table_full_o         (table_full_o),
    .access_done_o        (access_done_o)
  );

endmodule
`default_nettype wire
